### rtl/parct_pkg.sv
// Shared types, constants and helpers for the point rotate/translate block.
// Used by every module under rtl/; depends on nothing.
package parct_pkg;

    // Coordinate and operand formats
    localparam int COORD_WIDTH = 32;
    localparam int COORD_FRAC  = 16;
    localparam int ANGLE_WIDTH = 16;
    localparam int SHIFT_WIDTH = 16;
    localparam int PHASE_WIDTH = 32;

    // Sine/cosine format: Q2.30, octant values unsigned in OCT_WIDTH bits
    localparam int TRIG_FRAC  = 30;
    localparam int TRIG_WIDTH = 32;
    localparam int OCT_WIDTH  = 31;
    localparam logic [OCT_WIDTH-1:0] TRIG_ONE    = OCT_WIDTH'(1) << TRIG_FRAC;
    localparam logic [OCT_WIDTH-1:0] HALF_PI_Q30 = OCT_WIDTH'(1686629713);

    // Polynomial divisors: first term, then one per refinement step; sine has none for its last
    localparam int SIN_INIT_DIV = 72;
    localparam int COS_INIT_DIV = 90;
    localparam int POLY_STEPS   = 4;
    localparam int SIN_DIV [POLY_STEPS-1] = '{42, 20, 6};
    localparam int COS_DIV [POLY_STEPS]   = '{56, 30, 12, 2};

    // Pipeline depths
    localparam int STEP_BASE   = 4;
    localparam int FE_LATENCY  = STEP_BASE + 2 * POLY_STEPS + 1;
    localparam int BE_LATENCY  = 3;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        MODE_ROT_X = 2'd0,
        MODE_ROT_Y = 2'd1,
        MODE_ROT_Z = 2'd2,
        MODE_MOVE  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t                          mode;
        logic signed [COORD_WIDTH-1:0]  in_x;
        logic signed [COORD_WIDTH-1:0]  in_y;
        logic signed [COORD_WIDTH-1:0]  in_z;
        logic [ANGLE_WIDTH-1:0]         turn_angle;
        logic signed [SHIFT_WIDTH-1:0]  shift_x;
        logic signed [SHIFT_WIDTH-1:0]  shift_y;
        logic signed [SHIFT_WIDTH-1:0]  shift_z;
    } item_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0]  out_x;
        logic signed [COORD_WIDTH-1:0]  out_y;
        logic signed [COORD_WIDTH-1:0]  out_z;
        logic                           clipped;
    } result_t;

    // Word handed from the front to the back through the queue
    typedef struct packed {
        mode_t                          mode;
        logic signed [COORD_WIDTH-1:0]  in_x;
        logic signed [COORD_WIDTH-1:0]  in_y;
        logic signed [COORD_WIDTH-1:0]  in_z;
        logic signed [SHIFT_WIDTH-1:0]  shift_x;
        logic signed [SHIFT_WIDTH-1:0]  shift_y;
        logic signed [SHIFT_WIDTH-1:0]  shift_z;
        logic signed [TRIG_WIDTH-1:0]   sin_k;
        logic signed [TRIG_WIDTH-1:0]   cos_k;
    } fe_word_t;

    // Queue status seen by the top level
    typedef struct packed {
        logic avail;
        logic full;
    } q_stat_t;

    // Exact quotient by a constant: multiply by its rounded-up reciprocal
    function automatic logic [OCT_WIDTH-1:0] const_quot(
        input logic [OCT_WIDTH-1:0] v,
        input logic [31:0]          magic,
        input int unsigned          sh
    );
        logic [63:0] p;
        p = 64'(v) * 64'(magic);
        return OCT_WIDTH'(p >> sh);
    endfunction

endpackage

### rtl/point_axis_rotate_translate.sv
// Top level of the 3D point rotate/translate block.
// Depends on parct_pkg, parct_front, parct_queue and parct_back.

// Takes one point per clock: an item is accepted whenever start is high and
// busy is low, and its result appears on result with done high after the
// sine/cosine evaluation in the front end, a register in the queue, and the
// products, rounding and saturation in the back end.
// The front end's depth is mostly the four polynomial steps of the sine/cosine
// evaluation, each a multiply stage followed by a reciprocal-multiply stage.
// Results are shown for one cycle only and must be captured then; since the
// back end drains the queue every cycle, busy stays low in normal operation
// and one item per clock is sustained.
module point_axis_rotate_translate #(
    parameter int QUEUE_DEPTH = parct_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  parct_pkg::item_t    item,
    output logic                done,
    output parct_pkg::result_t  result
);

    logic                accept;
    logic                fe_valid;
    parct_pkg::fe_word_t fe_word;
    parct_pkg::fe_word_t q_word;
    parct_pkg::q_stat_t  q_stat;

    assign busy   = q_stat.full;
    assign accept = start && !busy;

    parct_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .out_valid(fe_valid),
        .out_word (fe_word)
    );

    parct_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fe_valid),
        .push_word(fe_word),
        .pop_word (q_word),
        .stat     (q_stat)
    );

    parct_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(q_stat.avail),
        .in_word (q_word),
        .done    (done),
        .result  (result)
    );

endmodule

### rtl/parct_front.sv
// Front end: takes items, folds the angle and evaluates sine/cosine in a
// pipeline of multiply stages. Depends on parct_pkg.
module parct_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  parct_pkg::item_t    item,
    output logic                out_valid,
    output parct_pkg::fe_word_t out_word
);

    localparam int OW        = parct_pkg::OCT_WIDTH;
    localparam int TF        = parct_pkg::TRIG_FRAC;
    localparam int PW        = parct_pkg::PHASE_WIDTH;
    localparam int LAT       = parct_pkg::FE_LATENCY;
    localparam int STEPS     = parct_pkg::POLY_STEPS;
    localparam int SIN_STEPS = STEPS - 1;
    localparam int BASE      = parct_pkg::STEP_BASE;
    localparam int LAST_OP   = BASE + 2 * STEPS - 2;
    localparam logic [OW-1:0] ONE = parct_pkg::TRIG_ONE;

    localparam int SIN_D0 = parct_pkg::SIN_INIT_DIV;
    localparam int COS_D0 = parct_pkg::COS_INIT_DIV;
    localparam logic [63:0] SIN_M0 =
        ((64'd1 << (OW + $clog2(SIN_D0))) + 64'(SIN_D0) - 64'd1) / 64'(SIN_D0);
    localparam logic [63:0] COS_M0 =
        ((64'd1 << (OW + $clog2(COS_D0))) + 64'(COS_D0) - 64'd1) / 64'(COS_D0);

    typedef struct packed {
        parct_pkg::mode_t                                mode;
        logic signed [parct_pkg::COORD_WIDTH-1:0]        in_x;
        logic signed [parct_pkg::COORD_WIDTH-1:0]        in_y;
        logic signed [parct_pkg::COORD_WIDTH-1:0]        in_z;
        logic signed [parct_pkg::SHIFT_WIDTH-1:0]        shift_x;
        logic signed [parct_pkg::SHIFT_WIDTH-1:0]        shift_y;
        logic signed [parct_pkg::SHIFT_WIDTH-1:0]        shift_z;
        logic [1:0]                                      quad;
        logic                                            swap;
    } side_t;

    logic [PW-1:0]   phase;
    logic [TF-1:0]   frac;
    logic            fold_hi;
    logic [TF-1:0]   folded;
    side_t           side_in;

    logic            vld_reg  [1:LAT];
    side_t           side_reg [1:LAT-1];
    logic [TF-1:0]   rr_reg;
    logic [TF-1:0]   t_reg    [2:LAST_OP];
    logic [TF-1:0]   t2_reg   [3:LAST_OP];
    logic [OW-1:0]   su_reg   [0:STEPS];
    logic [OW-1:0]   cu_reg   [0:STEPS];
    logic [OW-1:0]   sp_reg   [0:STEPS-1];
    logic [OW-1:0]   cp_reg   [0:STEPS-1];
    parct_pkg::fe_word_t word_reg;
    parct_pkg::fe_word_t word_next;

    // Fold the phase into the first octant
    always_comb
    begin
        phase   = PW'(item.turn_angle) << (PW - parct_pkg::ANGLE_WIDTH);
        frac    = phase[TF-1:0];
        fold_hi = frac > (TF'(1) << (TF - 1));
        folded  = fold_hi ? TF'((OW'(1) << TF) - OW'(frac)) : frac;
        side_in.mode    = item.mode;
        side_in.in_x    = item.in_x;
        side_in.in_y    = item.in_y;
        side_in.in_z    = item.in_z;
        side_in.shift_x = item.shift_x;
        side_in.shift_y = item.shift_y;
        side_in.shift_z = item.shift_z;
        side_in.quad    = phase[PW-1:PW-2];
        side_in.swap    = fold_hi;
    end

    // Advance the valid marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            vld_reg[1] <= accept;
            for (int i = 2; i <= LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // Scale to radians, square, and form the first polynomial terms
    always_ff @(posedge clk)
    begin
        side_reg[1] <= side_in;
        for (int i = 2; i < LAT; i++)
            side_reg[i] <= side_reg[i-1];
        rr_reg    <= folded;
        t_reg[2]  <= TF'((64'(rr_reg) * 64'(parct_pkg::HALF_PI_Q30)) >> TF);
        t2_reg[3] <= TF'((64'(t_reg[2]) * 64'(t_reg[2])) >> TF);
        for (int i = 3; i <= LAST_OP; i++)
            t_reg[i] <= t_reg[i-1];
        for (int i = 4; i <= LAST_OP; i++)
            t2_reg[i] <= t2_reg[i-1];
        su_reg[0] <= ONE - parct_pkg::const_quot(OW'(t2_reg[3]), 32'(SIN_M0),
                                                 OW + $clog2(SIN_D0));
        cu_reg[0] <= ONE - parct_pkg::const_quot(OW'(t2_reg[3]), 32'(COS_M0),
                                                 OW + $clog2(COS_D0));
    end

    // One refinement step per pair of stages: multiply, then divide and subtract
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam int AS = BASE + 2 * k;
        localparam int CD = parct_pkg::COS_DIV[k];
        localparam logic [63:0] CM =
            ((64'd1 << (OW + $clog2(CD))) + 64'(CD) - 64'd1) / 64'(CD);

        logic [OW-1:0] sin_mul;

        assign sin_mul = (k < SIN_STEPS) ? OW'(t2_reg[AS]) : OW'(t_reg[AS]);

        always_ff @(posedge clk)
        begin
            sp_reg[k]   <= OW'((64'(sin_mul) * 64'(su_reg[k])) >> TF);
            cp_reg[k]   <= OW'((64'(t2_reg[AS]) * 64'(cu_reg[k])) >> TF);
            cu_reg[k+1] <= ONE - parct_pkg::const_quot(cp_reg[k], 32'(CM),
                                                       OW + $clog2(CD));
        end

        if (k < SIN_STEPS)
        begin : g_sin_poly
            localparam int SD = parct_pkg::SIN_DIV[k];
            localparam logic [63:0] SM =
                ((64'd1 << (OW + $clog2(SD))) + 64'(SD) - 64'd1) / 64'(SD);
            always_ff @(posedge clk)
            begin
                su_reg[k+1] <= ONE - parct_pkg::const_quot(sp_reg[k], 32'(SM),
                                                           OW + $clog2(SD));
            end
        end
        else
        begin : g_sin_end
            // Last sine step is the product with t itself
            always_ff @(posedge clk)
            begin
                su_reg[k+1] <= sp_reg[k];
            end
        end
    end

    // Unfold the octant and map by quadrant
    always_comb
    begin
        logic signed [parct_pkg::TRIG_WIDTH-1:0] s_o;
        logic signed [parct_pkg::TRIG_WIDTH-1:0] c_o;
        s_o = side_reg[LAT-1].swap ? parct_pkg::TRIG_WIDTH'(cu_reg[STEPS])
                                   : parct_pkg::TRIG_WIDTH'(su_reg[STEPS]);
        c_o = side_reg[LAT-1].swap ? parct_pkg::TRIG_WIDTH'(su_reg[STEPS])
                                   : parct_pkg::TRIG_WIDTH'(cu_reg[STEPS]);
        word_next.mode    = side_reg[LAT-1].mode;
        word_next.in_x    = side_reg[LAT-1].in_x;
        word_next.in_y    = side_reg[LAT-1].in_y;
        word_next.in_z    = side_reg[LAT-1].in_z;
        word_next.shift_x = side_reg[LAT-1].shift_x;
        word_next.shift_y = side_reg[LAT-1].shift_y;
        word_next.shift_z = side_reg[LAT-1].shift_z;
        case (side_reg[LAT-1].quad)
            2'd0:
            begin
                word_next.sin_k = s_o;
                word_next.cos_k = c_o;
            end
            2'd1:
            begin
                word_next.sin_k = c_o;
                word_next.cos_k = -s_o;
            end
            2'd2:
            begin
                word_next.sin_k = -s_o;
                word_next.cos_k = -c_o;
            end
            default:
            begin
                word_next.sin_k = -c_o;
                word_next.cos_k = s_o;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = vld_reg[LAT];
    assign out_word  = word_reg;

`ifndef SYNTHESIS
    a_fe_latency: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(accept, LAT))
        else $error("front word without an item accepted at the pipeline depth");
`endif

endmodule

### rtl/parct_queue.sv
// Short register queue between the front and the back end.
// Depends on parct_pkg for the word and status types.
module parct_queue #(
    parameter int DEPTH = parct_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  parct_pkg::fe_word_t  push_word,
    output parct_pkg::fe_word_t  pop_word,
    output parct_pkg::q_stat_t   stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    parct_pkg::fe_word_t entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                pop;

    // The back end takes a word in every cycle one is there
    assign pop        = count_reg != '0;
    assign stat.avail = pop;
    assign stat.full  = count_reg == CNT_W'(DEPTH);
    assign pop_word   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
        end
    end

    // Hold words
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_word;
    end

`ifndef SYNTHESIS
    a_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full || pop)
        else $error("queue written while full");
    a_q_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

### rtl/parct_back.sv
// Back end: two-term dot products or translation, rounding and saturation.
// Depends on parct_pkg.
module parct_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  parct_pkg::fe_word_t in_word,
    output logic                done,
    output parct_pkg::result_t  result
);

    localparam int CW   = parct_pkg::COORD_WIDTH;
    localparam int KW   = parct_pkg::TRIG_WIDTH;
    localparam int PW   = CW + KW;
    localparam int WIDE = CW + 3;
    localparam int TF   = parct_pkg::TRIG_FRAC;
    localparam logic signed [PW:0]     RND    = (PW+1)'(1) <<< (TF - 1);
    localparam logic signed [WIDE-1:0] SAT_HI = (WIDE'(1) <<< (CW - 1)) - WIDE'(1);
    localparam logic signed [WIDE-1:0] SAT_LO = -(WIDE'(1) <<< (CW - 1));

    typedef struct packed {
        logic signed [CW-1:0] val;
        logic                 clip;
    } sat_t;

    function automatic sat_t saturate(input logic signed [WIDE-1:0] v);
        sat_t r;
        r.clip = 1'b1;
        if (v > SAT_HI)
            r.val = CW'(SAT_HI);
        else if (v < SAT_LO)
            r.val = CW'(SAT_LO);
        else
        begin
            r.val  = CW'(v);
            r.clip = 1'b0;
        end
        return r;
    endfunction

    logic signed [CW-1:0]   a_op;
    logic signed [CW-1:0]   b_op;
    logic signed [KW-1:0]   kp_op;
    logic signed [KW-1:0]   kq_op;

    logic                   v1_reg;
    logic                   v2_reg;
    logic                   done_reg;
    parct_pkg::fe_word_t    w1_reg;
    logic signed [PW-1:0]   pac_reg;
    logic signed [PW-1:0]   pbp_reg;
    logic signed [PW-1:0]   paq_reg;
    logic signed [PW-1:0]   pbc_reg;

    logic signed [PW:0]     p_sum;
    logic signed [PW:0]     q_sum;
    logic signed [WIDE-1:0] p_val;
    logic signed [WIDE-1:0] q_val;
    logic signed [WIDE-1:0] mx;
    logic signed [WIDE-1:0] my;
    logic signed [WIDE-1:0] mz;
    logic signed [WIDE-1:0] wx_next;
    logic signed [WIDE-1:0] wy_next;
    logic signed [WIDE-1:0] wz_next;
    logic signed [WIDE-1:0] wx_reg;
    logic signed [WIDE-1:0] wy_reg;
    logic signed [WIDE-1:0] wz_reg;
    sat_t                   sx;
    sat_t                   sy;
    sat_t                   sz;
    parct_pkg::result_t     result_reg;

    // Pick the two coordinates and coefficient signs for the axis
    always_comb
    begin
        unique case (in_word.mode) inside
            parct_pkg::MODE_ROT_X:
            begin
                a_op  = in_word.in_y;
                b_op  = in_word.in_z;
                kp_op = -in_word.sin_k;
                kq_op = in_word.sin_k;
            end
            parct_pkg::MODE_ROT_Y:
            begin
                a_op  = in_word.in_x;
                b_op  = in_word.in_z;
                kp_op = in_word.sin_k;
                kq_op = -in_word.sin_k;
            end
            parct_pkg::MODE_ROT_Z, parct_pkg::MODE_MOVE:
            begin
                a_op  = in_word.in_x;
                b_op  = in_word.in_y;
                kp_op = -in_word.sin_k;
                kq_op = in_word.sin_k;
            end
            default:
            begin
                a_op  = in_word.in_x;
                b_op  = in_word.in_y;
                kp_op = -in_word.sin_k;
                kq_op = in_word.sin_k;
            end
        endcase
    end

    // Advance the valid marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    // Round the dot products, form translations, pick the outputs by mode and saturate
    always_comb
    begin
        p_sum = (PW+1)'(pac_reg) + (PW+1)'(pbp_reg) + RND;
        q_sum = (PW+1)'(paq_reg) + (PW+1)'(pbc_reg) + RND;
        p_val = WIDE'(p_sum >>> TF);
        q_val = WIDE'(q_sum >>> TF);
        mx = WIDE'(w1_reg.in_x) + (WIDE'(w1_reg.shift_x) <<< parct_pkg::COORD_FRAC);
        my = WIDE'(w1_reg.in_y) + (WIDE'(w1_reg.shift_y) <<< parct_pkg::COORD_FRAC);
        mz = WIDE'(w1_reg.in_z) + (WIDE'(w1_reg.shift_z) <<< parct_pkg::COORD_FRAC);
        unique case (w1_reg.mode)
            parct_pkg::MODE_ROT_X:
            begin
                wx_next = WIDE'(w1_reg.in_x);
                wy_next = p_val;
                wz_next = q_val;
            end
            parct_pkg::MODE_ROT_Y:
            begin
                wx_next = p_val;
                wy_next = WIDE'(w1_reg.in_y);
                wz_next = q_val;
            end
            parct_pkg::MODE_ROT_Z:
            begin
                wx_next = p_val;
                wy_next = q_val;
                wz_next = WIDE'(w1_reg.in_z);
            end
            default:
            begin
                wx_next = mx;
                wy_next = my;
                wz_next = mz;
            end
        endcase
        sx = saturate(wx_reg);
        sy = saturate(wy_reg);
        sz = saturate(wz_reg);
    end

    // Multiply, sum, then saturate into the output register
    always_ff @(posedge clk)
    begin
        w1_reg  <= in_word;
        pac_reg <= PW'(a_op) * PW'(in_word.cos_k);
        pbp_reg <= PW'(b_op) * PW'(kp_op);
        paq_reg <= PW'(a_op) * PW'(kq_op);
        pbc_reg <= PW'(b_op) * PW'(in_word.cos_k);
        wx_reg  <= wx_next;
        wy_reg  <= wy_next;
        wz_reg  <= wz_next;
        result_reg.out_x   <= sx.val;
        result_reg.out_y   <= sy.val;
        result_reg.out_z   <= sz.val;
        result_reg.clipped <= sx.clip | sy.clip | sz.clip;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_be_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_valid, parct_pkg::BE_LATENCY))
        else $error("result without a word taken at the back end depth");
`endif

endmodule
